### sv/kda_pkg.sv
// Shared types, mode codes, register indexes and helpers for the key debounce engine.
package kda_pkg;

    localparam int TICK_W = 10;
    localparam int MODE_W = 3;
    localparam int CFG_AW = 3;

    localparam logic [MODE_W-1:0] MODE_UP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PDB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ACC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TURBO = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RDB   = 3'd5;

    localparam logic [CFG_AW-1:0] REG_PRESS_DB   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEP_HOLD  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ACCEL_HOLD = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RELEASE_DB = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ACCEL_REP  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TURBO_REP  = 3'd5;

    localparam logic [TICK_W-1:0] RST_PRESS_DB   = 10'd4;
    localparam logic [TICK_W-1:0] RST_STEP_HOLD  = 10'd120;
    localparam logic [TICK_W-1:0] RST_ACCEL_HOLD = 10'd360;
    localparam logic [TICK_W-1:0] RST_RELEASE_DB = 10'd3;
    localparam logic [TICK_W-1:0] RST_ACCEL_REP  = 10'd12;
    localparam logic [TICK_W-1:0] RST_TURBO_REP  = 10'd1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TICK_W-1:0] hold_count;
        logic              hold_expired;
        logic [TICK_W-1:0] repeat_count;
        logic              repeat_expired;
    } key_state_t;

    typedef struct packed {
        logic [TICK_W-1:0] press_db;
        logic [TICK_W-1:0] step_hold;
        logic [TICK_W-1:0] accel_hold;
        logic [TICK_W-1:0] release_db;
        logic [TICK_W-1:0] accel_rep;
        logic [TICK_W-1:0] turbo_rep;
    } cfg_t;

    typedef struct packed {
        key_state_t state;
        logic       step_event;
    } key_update_t;

    function automatic logic [TICK_W-1:0] load_val(input logic [TICK_W-1:0] n);
        load_val = (n == '0) ? TICK_W'(1) : n;
    endfunction

endpackage

### sv/key_debounce_autorepeat.sv
// Top level: per-key debounce and accelerating auto-repeat engine with stream ports.
//
// Each input word is one tick for one key (key_select, key_down); each tick yields
// exactly one result word (step_event, key_mode_out) with the key's new mode. Ticks
// are accepted one per cycle while the output is not stalled, back to back, including
// repeated ticks for the same key: a word waits in the input register, the key's state
// is read, updated and written back by one pass of the next-state logic, and the result
// is written into the output register once that register can take it. Throughput is one
// word per cycle while the output is not stalled, set by the single read-modify-write
// of the per-key state registers.
// A key_select at or beyond KEYS gives a zero result and changes nothing. Configuration
// writes take effect at once and are meant for idle periods; index 6 and 7 are ignored.
module key_debounce_autorepeat
    import kda_pkg::*;
#(
    parameter int KEYS = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [2:0] key_select, [3] key_down, [7:4] zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] step_event, [3:1] key_mode_out, [7:4] zero
    input  logic              cfg_wen,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [TICK_W-1:0] cfg_wdata
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;

    cfg_t              cfg_reg;
    key_state_t        st_reg [KEYS];

    logic              in_valid_reg;
    logic [2:0]        key_reg;
    logic              down_reg;
    logic              out_valid_reg;
    logic              step_reg;
    logic [MODE_W-1:0] mode_reg;

    logic              advance;
    logic              key_in_range;
    logic [KW+2:0]     key_wide;
    logic [KW-1:0]     key_idx;
    key_state_t        cur_state;
    key_update_t       upd;
    logic              step_next;
    logic [MODE_W-1:0] mode_next;

    assign advance      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready     = !in_valid_reg || advance;
    assign key_in_range = {2'b00, key_reg} < 5'(KEYS);
    assign key_wide     = {{KW{1'b0}}, key_reg};
    assign key_idx      = key_wide[KW-1:0];
    assign cur_state    = key_in_range ? st_reg[key_idx] : '0;

    kda_key_fsm u_fsm (
        .cur      (cur_state),
        .key_down (down_reg),
        .cfg      (cfg_reg),
        .upd      (upd)
    );

    assign step_next = key_in_range ? upd.step_event : 1'b0;
    assign mode_next = key_in_range ? upd.state.mode : MODE_UP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_db   <= RST_PRESS_DB;
            cfg_reg.step_hold  <= RST_STEP_HOLD;
            cfg_reg.accel_hold <= RST_ACCEL_HOLD;
            cfg_reg.release_db <= RST_RELEASE_DB;
            cfg_reg.accel_rep  <= RST_ACCEL_REP;
            cfg_reg.turbo_rep  <= RST_TURBO_REP;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_PRESS_DB:   cfg_reg.press_db   <= cfg_wdata;
                REG_STEP_HOLD:  cfg_reg.step_hold  <= cfg_wdata;
                REG_ACCEL_HOLD: cfg_reg.accel_hold <= cfg_wdata;
                REG_RELEASE_DB: cfg_reg.release_db <= cfg_wdata;
                REG_ACCEL_REP:  cfg_reg.accel_rep  <= cfg_wdata;
                REG_TURBO_REP:  cfg_reg.turbo_rep  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEYS; k++) begin
                st_reg[k] <= '0;
            end
        end else if (advance && key_in_range) begin
            st_reg[key_idx] <= upd.state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            key_reg  <= s_tdata[2:0];
            down_reg <= s_tdata[3];
        end
        if (advance) begin
            step_reg <= step_next;
            mode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, mode_reg, step_reg};

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !key_in_range) |=> (m_tvalid && !m_tdata[0] && m_tdata[3:1] == MODE_UP))
        else $error("out-of-range key gave a nonzero result");

    a_step_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == MODE_STEP || m_tdata[3:1] == MODE_ACC
                                      || m_tdata[3:1] == MODE_TURBO))
        else $error("step pulse with a mode that cannot step");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(key_reg) && $stable(down_reg)))
        else $error("pending input word lost while output stalled");

    a_legal_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tdata[3:1] == MODE_UP || m_tdata[3:1] == MODE_PDB
                     || m_tdata[3:1] == MODE_STEP || m_tdata[3:1] == MODE_ACC
                     || m_tdata[3:1] == MODE_TURBO || m_tdata[3:1] == MODE_RDB))
        else $error("result mode outside the legal set");

endmodule

### sv/kda_key_fsm.sv
// Next-state rule for one key: timer countdown, mode transitions and step pulse.
module kda_key_fsm
    import kda_pkg::*;
(
    input  key_state_t  cur,
    input  logic        key_down,
    input  cfg_t        cfg,
    output key_update_t upd
);

    logic [TICK_W-1:0] hc;
    logic              hf;
    logic [TICK_W-1:0] rc;
    logic              rf;
    logic [MODE_W-1:0] mode;
    logic              step;
    logic              take_h;
    logic              take_r;

    always_comb begin
        hc     = cur.hold_count;
        hf     = cur.hold_expired;
        rc     = cur.repeat_count;
        rf     = cur.repeat_expired;
        mode   = cur.mode;
        step   = 1'b0;
        take_h = 1'b0;
        take_r = 1'b0;

        // count down both timers
        if (hc != '0) begin
            hc = hc - TICK_W'(1);
            if (hc == '0) begin
                hf = 1'b1;
            end
        end
        if (rc != '0) begin
            rc = rc - TICK_W'(1);
            if (rc == '0) begin
                rf = 1'b1;
            end
        end

        case (mode)
            MODE_UP: begin
                if (key_down) begin
                    rf   = 1'b0;
                    hc   = load_val(cfg.press_db);
                    hf   = 1'b0;
                    mode = MODE_PDB;
                end
            end
            MODE_PDB: begin
                take_h = hf;
                hf     = 1'b0;
                if (take_h) begin
                    if (key_down) begin
                        rf   = 1'b0;
                        hc   = load_val(cfg.step_hold);
                        step = 1'b1;
                        mode = MODE_STEP;
                    end else begin
                        mode = MODE_UP;
                    end
                end
            end
            MODE_STEP, MODE_ACC, MODE_TURBO: begin
                if (!key_down) begin
                    rf   = 1'b0;
                    hc   = load_val(cfg.release_db);
                    hf   = 1'b0;
                    mode = MODE_RDB;
                end else if (mode == MODE_STEP) begin
                    take_h = hf;
                    hf     = 1'b0;
                    if (take_h) begin
                        rc   = load_val(cfg.accel_rep);
                        rf   = 1'b0;
                        hc   = load_val(cfg.accel_hold);
                        step = 1'b1;
                        mode = MODE_ACC;
                    end
                end else if (mode == MODE_ACC) begin
                    take_r = rf;
                    rf     = 1'b0;
                    if (take_r) begin
                        rc   = load_val(cfg.accel_rep);
                        step = 1'b1;
                    end
                    take_h = hf;
                    hf     = 1'b0;
                    if (take_h) begin
                        rc   = load_val(cfg.turbo_rep);
                        step = 1'b1;
                        mode = MODE_TURBO;
                    end
                end else begin
                    take_r = rf;
                    rf     = 1'b0;
                    if (take_r) begin
                        rc   = load_val(cfg.turbo_rep);
                        step = 1'b1;
                    end
                end
            end
            MODE_RDB: begin
                take_h = hf;
                hf     = 1'b0;
                if (take_h) begin
                    mode = MODE_UP;
                end
            end
            default: begin
                rf   = 1'b0;
                hf   = 1'b0;
                mode = MODE_UP;
            end
        endcase

        upd.state.mode           = mode;
        upd.state.hold_count     = hc;
        upd.state.hold_expired   = hf;
        upd.state.repeat_count   = rc;
        upd.state.repeat_expired = rf;
        upd.step_event           = step;
    end

endmodule
